// ===== rtl/mlrq_pkg.sv =====
// Shared types, codes and constants for the multilevel ready-queue scheduler.
`timescale 1ns / 1ps
package mlrq_pkg;

    localparam int MAX_TASKS    = 64;
    localparam int TASK_W       = 6;
    localparam int LEVEL_W      = 3;
    localparam int LEVELS_DEF   = 8;
    localparam int PERIOD_W     = 16;
    localparam int PROMO_W      = 7;
    localparam int REQ_W        = 2;
    localparam int STATUS_W     = 2;

    localparam logic [PERIOD_W-1:0] AGING_RESET = 16'd8;
    localparam logic [PROMO_W-1:0]  PROMO_MAX   = 7'd127;

    localparam logic [REQ_W-1:0] REQ_ENQ  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEL  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IDLE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;

    typedef enum logic [1:0] {
        OP_ENQ,
        OP_SEL,
        OP_TICK,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [TASK_W-1:0] task_num;
        logic [LEVEL_W-1:0] level;
    } t_cmd;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_ENQ,
        BK_NOP,
        BK_SEL,
        BK_SEL_WB,
        BK_T_LEVEL,
        BK_T_RD,
        BK_T_EXE,
        BK_T_APP
    } t_bk_state;

endpackage

// ===== rtl/multilevel_ready_queue_aging.sv =====
// Top level of the multilevel ready-queue scheduler with aging.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------------------------
//  request  | in        | i_in_valid / o_in_stall    | i_req_type, i_task_number, i_level
//  result   | out       | o_out_valid / i_out_stall  | o_chosen_task, o_status, o_promoted_count
//  config   | in        | i_cfg_wr_en (no wait)      | i_cfg_wr_data (aging period)
//
// Steps per transfer: enqueue and unknown requests are handled in their own execute state; select
// adds a next-link read state when the level holds more than one task. A tick visits each
// level; each task visit is one memory read and an execute state, plus an append if promoted.
// Reset (synchronous, active low) empties every level and the request queue and loads
// the aging period with 8; link and counter memories need no clearing.
// The two-entry request queue accepts while a stalled result holds the back end.
`timescale 1ns / 1ps
module multilevel_ready_queue_aging
    import mlrq_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [TASK_W-1:0]   i_task_number,
    input  logic [LEVEL_W-1:0]  i_level,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [TASK_W-1:0]   o_chosen_task,
    output logic [STATUS_W-1:0] o_status,
    output logic [PROMO_W-1:0]  o_promoted_count,
    input  logic                i_cfg_wr_en,
    input  logic [PERIOD_W-1:0] i_cfg_wr_data
);

    logic [PERIOD_W-1:0] r_aging_period;
    logic                cmd_valid;
    t_cmd                cmd;
    logic                cmd_pop;

    // aging period register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aging_period <= AGING_RESET;
        end else if (i_cfg_wr_en) begin
            r_aging_period <= i_cfg_wr_data;
        end
    end

    mlrq_front #(
        .LEVELS (LEVELS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_stall       (o_in_stall),
        .i_req_type    (i_req_type),
        .i_task_number (i_task_number),
        .i_level       (i_level),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_pop         (cmd_pop)
    );

    mlrq_back #(
        .LEVELS (LEVELS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (cmd_valid),
        .i_cmd            (cmd),
        .o_pop            (cmd_pop),
        .i_aging_period   (r_aging_period),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_chosen_task    (o_chosen_task),
        .o_status         (o_status),
        .o_promoted_count (o_promoted_count)
    );

    // back end never takes from an empty queue
    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("request popped from empty queue");

    // an idle report carries no task and no promotions
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_IDLE)) |->
            ((o_chosen_task == '0) && (o_promoted_count == '0)))
        else $error("idle result carries data");

    // a rejected enqueue carries no task and no promotions
    a_dup_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_DUP)) |->
            ((o_chosen_task == '0) && (o_promoted_count == '0)))
        else $error("duplicate result carries data");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

// ===== rtl/mlrq_front.sv =====
// Front end: decodes incoming requests and buffers them in a two-entry queue.
`timescale 1ns / 1ps
module mlrq_front
    import mlrq_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [TASK_W-1:0]  i_task_number,
    input  logic [LEVEL_W-1:0] i_level,
    output logic               o_cmd_valid,
    output t_cmd               o_cmd,
    input  logic               i_pop
);

    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       r_wr;
    logic       r_rd;
    t_cmd       r_q [2];
    t_cmd       dec;
    logic       push;

    assign o_stall     = (r_count == 2'd2);
    assign push        = i_valid && !o_stall;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        dec.task_num = i_task_number;
        if (int'(i_level) >= LEVELS) begin
            dec.level = LEVEL_W'(LEVELS - 1);
        end else begin
            dec.level = i_level;
        end
        unique case (i_req_type)
            REQ_ENQ:  dec.op = OP_ENQ;
            REQ_SEL:  dec.op = OP_SEL;
            REQ_TICK: dec.op = OP_TICK;
            default:  dec.op = OP_NOP;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= dec;
        end
    end

endmodule

// ===== rtl/mlrq_back.sv =====
// Back end: executes enqueue, select and aging tick against the level lists; other requests get an OK result.
`timescale 1ns / 1ps
module mlrq_back
    import mlrq_pkg::*;
#(
    parameter int LEVELS = LEVELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  t_cmd                i_cmd,
    output logic                o_pop,
    input  logic [PERIOD_W-1:0] i_aging_period,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [TASK_W-1:0]   o_chosen_task,
    output logic [STATUS_W-1:0] o_status,
    output logic [PROMO_W-1:0]  o_promoted_count
);

    localparam int LVL_W = $clog2(LEVELS);

    t_bk_state r_state, n_state;

    // level list registers
    logic [TASK_W-1:0] r_head [LEVELS];
    logic [TASK_W-1:0] n_head [LEVELS];
    logic [TASK_W-1:0] r_tail [LEVELS];
    logic [TASK_W-1:0] n_tail [LEVELS];
    logic [LEVELS-1:0] r_nonempty, n_nonempty;
    logic [MAX_TASKS-1:0] r_queued, n_queued;
    logic [MAX_TASKS-1:0] r_moved, n_moved;

    // walk registers
    t_cmd              r_cmd, n_cmd;
    logic [LVL_W-1:0]  r_lv, n_lv;
    logic [TASK_W-1:0] r_cur, n_cur;
    logic [TASK_W-1:0] r_prev, n_prev;
    logic [TASK_W-1:0] r_nxt, n_nxt;
    logic              r_has_prev, n_has_prev;
    logic              r_last, n_last;
    logic [PROMO_W-1:0] r_count, n_count;

    // result register
    logic                r_out_valid, n_out_valid;
    logic [TASK_W-1:0]   r_chosen, n_chosen;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [PROMO_W-1:0]  r_promo, n_promo;

    // memories
    logic [TASK_W-1:0]   lnk_mem [MAX_TASKS];
    logic [PERIOD_W-1:0] wc_mem  [MAX_TASKS];
    logic [TASK_W-1:0]   rd_addr;
    logic [TASK_W-1:0]   r_lnk_rdata;
    logic [PERIOD_W-1:0] r_wc_rdata;
    logic                lnk_we, wc_we;
    logic [TASK_W-1:0]   lnk_waddr, wc_waddr;
    logic [TASK_W-1:0]   lnk_wdata;
    logic [PERIOD_W-1:0] wc_wdata;

    logic              slot_free;
    logic              sel_found;
    logic [LVL_W-1:0]  sel_lv;
    logic              cur_last;
    logic [LVL_W-1:0]  enq_lv;
    logic [LVL_W-1:0]  dst_lv;

    assign slot_free = !r_out_valid || !i_out_stall;
    assign o_pop     = (r_state == BK_IDLE) && i_cmd_valid && slot_free;
    assign cur_last  = (r_cur == r_tail[r_lv]);
    assign enq_lv    = LVL_W'(r_cmd.level);
    assign dst_lv    = r_lv - LVL_W'(1);

    assign o_out_valid      = r_out_valid;
    assign o_chosen_task    = r_chosen;
    assign o_status         = r_status;
    assign o_promoted_count = r_promo;

    // lowest-numbered non-empty level (level 0 is served first)
    always_comb begin
        sel_found = 1'b0;
        sel_lv    = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_nonempty[i]) begin
                sel_found = 1'b1;
                sel_lv    = LVL_W'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (o_pop) begin
                    unique case (i_cmd.op)
                        OP_ENQ:  n_state = BK_ENQ;
                        OP_SEL:  n_state = BK_SEL;
                        OP_TICK: n_state = BK_T_LEVEL;
                        default: n_state = BK_NOP;
                    endcase
                end
            end
            BK_ENQ, BK_NOP, BK_SEL_WB: n_state = BK_IDLE;
            BK_SEL: begin
                if (sel_found && (r_head[sel_lv] != r_tail[sel_lv])) begin
                    n_state = BK_SEL_WB;
                end else begin
                    n_state = BK_IDLE;
                end
            end
            BK_T_LEVEL: begin
                if (r_lv == '0) begin
                    n_state = BK_IDLE;
                end else if (r_nonempty[r_lv]) begin
                    n_state = BK_T_RD;
                end
            end
            BK_T_RD: n_state = BK_T_EXE;
            BK_T_EXE: begin
                if (r_wc_rdata == '0) begin
                    n_state = BK_T_APP;
                end else if (cur_last) begin
                    n_state = BK_T_LEVEL;
                end else begin
                    n_state = BK_T_RD;
                end
            end
            BK_T_APP: n_state = r_last ? BK_T_LEVEL : BK_T_RD;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_nonempty  = r_nonempty;
        n_queued    = r_queued;
        n_moved     = r_moved;
        n_cmd       = r_cmd;
        n_lv        = r_lv;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_nxt       = r_nxt;
        n_has_prev  = r_has_prev;
        n_last      = r_last;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_chosen    = r_chosen;
        n_status    = r_status;
        n_promo     = r_promo;
        rd_addr     = r_cur;
        lnk_we      = 1'b0;
        lnk_waddr   = '0;
        lnk_wdata   = '0;
        wc_we       = 1'b0;
        wc_waddr    = '0;
        wc_wdata    = '0;
        unique case (r_state)
            BK_IDLE: begin
                if (o_pop) begin
                    n_cmd   = i_cmd;
                    n_lv    = LVL_W'(LEVELS - 1);
                    n_count = '0;
                    n_moved = '0;
                end
            end
            BK_NOP: begin
                n_out_valid = 1'b1;
                n_chosen    = '0;
                n_status    = ST_OK;
                n_promo     = '0;
            end
            BK_ENQ: begin
                n_out_valid = 1'b1;
                n_chosen    = '0;
                n_promo     = '0;
                if (r_queued[r_cmd.task_num]) begin
                    n_status = ST_DUP;
                end else begin
                    n_status = ST_OK;
                    if (r_nonempty[enq_lv]) begin
                        lnk_we    = 1'b1;
                        lnk_waddr = r_tail[enq_lv];
                        lnk_wdata = r_cmd.task_num;
                    end else begin
                        n_head[enq_lv]     = r_cmd.task_num;
                        n_nonempty[enq_lv] = 1'b1;
                    end
                    n_tail[enq_lv]            = r_cmd.task_num;
                    n_queued[r_cmd.task_num]  = 1'b1;
                    wc_we    = 1'b1;
                    wc_waddr = r_cmd.task_num;
                    wc_wdata = i_aging_period;
                end
            end
            BK_SEL: begin
                rd_addr = r_head[sel_lv];
                n_lv    = sel_lv;
                n_cur   = r_head[sel_lv];
                if (!sel_found) begin
                    n_out_valid = 1'b1;
                    n_chosen    = '0;
                    n_status    = ST_IDLE;
                    n_promo     = '0;
                end else begin
                    n_queued[r_head[sel_lv]] = 1'b0;
                    if (r_head[sel_lv] == r_tail[sel_lv]) begin
                        n_nonempty[sel_lv] = 1'b0;
                        n_out_valid = 1'b1;
                        n_chosen    = r_head[sel_lv];
                        n_status    = ST_OK;
                        n_promo     = '0;
                    end
                end
            end
            BK_SEL_WB: begin
                n_head[r_lv] = r_lnk_rdata;
                n_out_valid  = 1'b1;
                n_chosen     = r_cur;
                n_status     = ST_OK;
                n_promo      = '0;
            end
            BK_T_LEVEL: begin
                if (r_lv == '0) begin
                    n_out_valid = 1'b1;
                    n_chosen    = '0;
                    n_status    = ST_OK;
                    n_promo     = r_count;
                end else if (r_nonempty[r_lv]) begin
                    n_cur      = r_head[r_lv];
                    n_has_prev = 1'b0;
                end else begin
                    n_lv = dst_lv;
                end
            end
            BK_T_RD: begin
                rd_addr = r_cur;
            end
            BK_T_EXE: begin
                if (r_wc_rdata != '0) begin
                    wc_we      = 1'b1;
                    wc_waddr   = r_cur;
                    wc_wdata   = r_wc_rdata - PERIOD_W'(1);
                    n_prev     = r_cur;
                    n_has_prev = 1'b1;
                    if (cur_last) begin
                        n_lv = dst_lv;
                    end else begin
                        n_cur = r_lnk_rdata;
                    end
                end else begin
                    // unlink the promoted task from its level
                    if (cur_last) begin
                        if (r_has_prev) begin
                            n_tail[r_lv] = r_prev;
                        end else begin
                            n_nonempty[r_lv] = 1'b0;
                        end
                    end else if (r_has_prev) begin
                        lnk_we    = 1'b1;
                        lnk_waddr = r_prev;
                        lnk_wdata = r_lnk_rdata;
                    end else begin
                        n_head[r_lv] = r_lnk_rdata;
                    end
                    n_nxt  = r_lnk_rdata;
                    n_last = cur_last;
                end
            end
            BK_T_APP: begin
                if (r_nonempty[dst_lv]) begin
                    lnk_we    = 1'b1;
                    lnk_waddr = r_tail[dst_lv];
                    lnk_wdata = r_cur;
                end else begin
                    n_head[dst_lv]     = r_cur;
                    n_nonempty[dst_lv] = 1'b1;
                end
                n_tail[dst_lv] = r_cur;
                wc_we    = 1'b1;
                wc_waddr = r_cur;
                wc_wdata = i_aging_period;
                if (!r_moved[r_cur]) begin
                    n_moved[r_cur] = 1'b1;
                    if (r_count != PROMO_MAX) begin
                        n_count = r_count + PROMO_W'(1);
                    end
                end
                if (r_last) begin
                    n_lv = dst_lv;
                end else begin
                    n_cur = r_nxt;
                end
            end
            default: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_nonempty  <= '0;
            r_queued    <= '0;
            r_moved     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_nonempty  <= n_nonempty;
            r_queued    <= n_queued;
            r_moved     <= n_moved;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head     <= n_head;
        r_tail     <= n_tail;
        r_cmd      <= n_cmd;
        r_lv       <= n_lv;
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_nxt      <= n_nxt;
        r_has_prev <= n_has_prev;
        r_last     <= n_last;
        r_count    <= n_count;
        r_chosen   <= n_chosen;
        r_status   <= n_status;
        r_promo    <= n_promo;
    end

    always_ff @(posedge i_clk) begin
        if (lnk_we) begin
            lnk_mem[lnk_waddr] <= lnk_wdata;
        end
        r_lnk_rdata <= lnk_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wc_we) begin
            wc_mem[wc_waddr] <= wc_wdata;
        end
        r_wc_rdata <= wc_mem[rd_addr];
    end

endmodule

// ===== tb/tb_multilevel_ready_queue_aging.sv =====
// Self-checking testbench for the multilevel ready-queue scheduler with aging.
`timescale 1ns / 1ps
module tb_multilevel_ready_queue_aging;
    import mlrq_pkg::*;

    localparam int NLEV       = 8;
    localparam int N_RANDOM   = 1050;
    localparam int STALL_MAX  = 8;
    localparam int WDOG_LIMIT = 20000;
    localparam int DRAIN_CYC  = 400;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [REQ_W-1:0]    req_type = '0;
    logic [TASK_W-1:0]   task_number = '0;
    logic [LEVEL_W-1:0]  level = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [TASK_W-1:0]   chosen_task;
    logic [STATUS_W-1:0] status;
    logic [PROMO_W-1:0]  promoted_count;
    logic                cfg_wr_en = 1'b0;
    logic [PERIOD_W-1:0] cfg_wr_data = '0;

    multilevel_ready_queue_aging #(.LEVELS(NLEV)) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_req_type      (req_type),
        .i_task_number   (task_number),
        .i_level         (level),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_chosen_task   (chosen_task),
        .o_status        (status),
        .o_promoted_count(promoted_count),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Scheduler image kept by the testbench: each level as a queue of tasks.
    typedef struct packed {
        logic [TASK_W-1:0]   chosen;
        logic [STATUS_W-1:0] st;
        logic [PROMO_W-1:0]  promo;
    } t_result;

    typedef struct {
        logic [REQ_W-1:0]   req;
        logic [TASK_W-1:0]  tsk;
        logic [LEVEL_W-1:0] lv;
        bit                 fixed;   // expected result typed in by hand
        t_result            res;
    } t_row;

    logic [TASK_W-1:0]   ready_q [NLEV][$];
    bit                  is_queued [MAX_TASKS];
    logic [PERIOD_W-1:0] wait_cnt [MAX_TASKS];
    logic [PERIOD_W-1:0] period_reg = AGING_RESET;

    t_result expected_results [$];
    int      n_errors   = 0;
    int      n_accepted = 0;
    int      n_checked  = 0;
    int      n_ticks    = 0;
    int      n_promoted = 0;
    int      quiet_cyc  = 0;
    int      out_phase  = 0;

    // Walk levels 7..1 head to tail; a promoted task is seen again one level up.
    function automatic logic [PROMO_W-1:0] age_levels();
        bit                moved [MAX_TASKS];
        int                cnt;
        logic [TASK_W-1:0] kept [$];
        logic [TASK_W-1:0] t;
        cnt = 0;
        foreach (moved[i]) moved[i] = 1'b0;
        for (int lv = NLEV - 1; lv > 0; lv--) begin
            kept.delete();
            while (ready_q[lv].size() > 0) begin
                t = ready_q[lv].pop_front();
                if (wait_cnt[t] == 0) begin
                    ready_q[lv-1].push_back(t);
                    wait_cnt[t] = period_reg;
                    if (!moved[t]) begin
                        moved[t] = 1'b1;
                        if (cnt < 127) cnt++;
                    end
                end else begin
                    wait_cnt[t]--;
                    kept.push_back(t);
                end
            end
            ready_q[lv] = kept;
        end
        return cnt[PROMO_W-1:0];
    endfunction

    function automatic t_result schedule_step(logic [REQ_W-1:0] rq, logic [TASK_W-1:0] tk,
                                              logic [LEVEL_W-1:0] lv);
        t_result r;
        r = '0;
        case (rq)
            REQ_ENQ: begin
                if (is_queued[tk]) begin
                    r.st = ST_DUP;
                end else begin
                    ready_q[lv].push_back(tk);
                    wait_cnt[tk]  = period_reg;
                    is_queued[tk] = 1'b1;
                end
            end
            REQ_SEL: begin
                r.st = ST_IDLE;
                for (int l = 0; l < NLEV; l++) begin
                    if (ready_q[l].size() > 0) begin
                        r.chosen = ready_q[l].pop_front();
                        is_queued[r.chosen] = 1'b0;
                        r.st = ST_OK;
                        break;
                    end
                end
            end
            REQ_TICK: begin
                r.promo = age_levels();
                n_ticks++;
                n_promoted += r.promo;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        n_errors++;
        $display("MISMATCH transfer %0d: %s got %0d expected %0d", n_checked, what, got, want);
    endtask

    // Receiver: stall on its own rhythm, with long runs of no stalling.
    always @(posedge i_clk) begin
        out_phase <= out_phase + 1;
        if (out_phase[8])
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    // Result check and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cyc <= 0;
            else
                quiet_cyc <= quiet_cyc + 1;
            if (quiet_cyc >= WDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result transfers expected", 0, 1);
                end else begin
                    t_result e;
                    e = expected_results.pop_front();
                    if (chosen_task !== e.chosen)
                        report_mismatch("chosen_task", chosen_task, e.chosen);
                    if (status !== e.st) report_mismatch("status", status, e.st);
                    if (promoted_count !== e.promo)
                        report_mismatch("promoted_count", promoted_count, e.promo);
                end
                n_checked++;
            end
        end
    end

    // One request transfer; the prediction is taken at the accepting edge.
    task automatic send_request(logic [REQ_W-1:0] rq, logic [TASK_W-1:0] tk,
                                logic [LEVEL_W-1:0] lv, bit fixed, t_result want);
        t_result p;
        in_valid    <= 1'b1;
        req_type    <= rq;
        task_number <= tk;
        level       <= lv;
        do @(posedge i_clk); while (in_stall);
        p = schedule_step(rq, tk, lv);
        if (fixed && p !== want)
            report_mismatch("directed row result", p, want);
        expected_results.push_back(p);
        n_accepted++;
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Drain, let any trailing work settle, then change the aging period.
    task automatic set_period(logic [PERIOD_W-1:0] v);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en  <= 1'b0;
        period_reg = v;
    endtask

    function automatic t_result mk(logic [TASK_W-1:0] c, logic [STATUS_W-1:0] s,
                                   logic [PROMO_W-1:0] p);
        t_result r;
        r.chosen = c;
        r.st     = s;
        r.promo  = p;
        return r;
    endfunction

    t_row dir_rows [$];

    initial begin
        int  burst;
        int  kind;
        int  live;
        logic [TASK_W-1:0] tk;

        foreach (is_queued[i]) begin
            is_queued[i] = 1'b0;
            wait_cnt[i]  = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: idle select, extremes, duplicate, unknown request, ticks.
        dir_rows.push_back('{REQ_SEL,  6'd63, 3'd7, 1, mk(0, ST_IDLE, 0)});
        dir_rows.push_back('{REQ_TICK, 6'd0,  3'd0, 1, mk(0, ST_OK, 0)});
        dir_rows.push_back('{REQ_ENQ,  6'd63, 3'd7, 1, mk(0, ST_OK, 0)});
        dir_rows.push_back('{REQ_ENQ,  6'd63, 3'd0, 1, mk(0, ST_DUP, 0)});
        dir_rows.push_back('{REQ_ENQ,  6'd0,  3'd0, 1, mk(0, ST_OK, 0)});
        dir_rows.push_back('{2'd3,     6'd21, 3'd5, 1, mk(0, ST_OK, 0)});
        dir_rows.push_back('{REQ_ENQ,  6'd42, 3'd7, 0, '0});
        dir_rows.push_back('{REQ_ENQ,  6'd21, 3'd3, 0, '0});
        dir_rows.push_back('{REQ_SEL,  6'd0,  3'd0, 1, mk(0, ST_OK, 0)});
        for (int i = 0; i < 9; i++) dir_rows.push_back('{REQ_TICK, 6'd0, 3'd0, 0, '0});
        for (int i = 0; i < 4; i++) dir_rows.push_back('{REQ_SEL, 6'd0, 3'd0, 0, '0});
        foreach (dir_rows[i])
            send_request(dir_rows[i].req, dir_rows[i].tsk, dir_rows[i].lv,
                         dir_rows[i].fixed, dir_rows[i].res);

        // Random phases; zero period lets tasks climb several levels per tick.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: set_period(16'd0);
                1: set_period(16'd2);
                2: set_period(16'hFFFF);
                3: set_period(16'($urandom_range(1, 6)));
                default: set_period(AGING_RESET);
            endcase
            live = 0;
            while (live < N_RANDOM / 5) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && live < N_RANDOM / 5; b++) begin
                    kind = $urandom_range(0, 99);
                    tk   = 6'($urandom);
                    if (kind < 50)
                        send_request(REQ_ENQ, tk, 3'($urandom), 0, '0);
                    else if (kind < 80)
                        send_request(REQ_SEL, tk, 3'($urandom), 0, '0);
                    else if (kind < 97)
                        send_request(REQ_TICK, tk, 3'($urandom), 0, '0);
                    else
                        send_request(2'd3, tk, 3'($urandom), 0, '0);
                    live++;
                end
                if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(0, STALL_MAX));
            end
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        $display("Covered %0d request transfers, %0d results checked", n_accepted, n_checked);
        $display("%0d aging ticks promoted %0d tasks in total", n_ticks, n_promoted);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/mlrq_pkg.sv
rtl/mlrq_front.sv
rtl/mlrq_back.sv
rtl/multilevel_ready_queue_aging.sv
tb/tb_multilevel_ready_queue_aging.sv
